>>> rtl/lcc_pkg.sv
package lcc_pkg;

  localparam int unsigned REF_CLOCK_HZ_DEF = 40000000;
  localparam int unsigned COUNT_BITS_DEF   = 28;

  localparam int CHAN_W    = 2;
  localparam int RAW_W     = 28;
  localparam int FIN_W     = 2;
  localparam int DIV_W     = 10;
  localparam int FREQ_W    = 27;
  localparam int CAP_W     = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 10;
  localparam int NUM_CH    = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FIN_SEL_CH0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_DIV_CH0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END         = 4'd8;

  localparam logic [FIN_W-1:0] FIN_SEL_RESET = 2'd2;
  localparam logic [DIV_W-1:0] REF_DIV_RESET = 10'd1;

  // Scaled frequency numerator width: fin * REF_CLOCK_HZ stays below 2^28.
  localparam int FR_W = 28;
  // Quotient bits produced by the divider; anything above is saturation.
  localparam int QB   = 33;
  // Tank constant in unsigned Q.48, split for two narrow multipliers.
  localparam int KQ_W  = 62;
  localparam int KQ_LW = 31;
  localparam int DIV2_W = 2 * DIV_W;

  localparam logic [63:0] CAP_K0 = 64'd1407238661699000;
  localparam logic [QB-1:0] CAP_OFFSET = QB'(37) << 16;
  localparam logic [QB-1:0] CAP_MAX    = QB'(32'h7FFF_FFFF);
  localparam logic [QB-1:0] CAP_LIM    = CAP_MAX + CAP_OFFSET;
  localparam logic [QB-1:0] FREQ_MAX   = QB'((64'd1 << FREQ_W) - 64'd1);

  typedef struct packed {
    logic valid;
    logic zero;
    logic ovf;
  } lcc_ctl_t;

endpackage

>>> rtl/lcc_in_if.sv
interface lcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcc_pkg::CHAN_W-1:0]  chan;
  logic [lcc_pkg::RAW_W-1:0]   raw_count;

  modport source (output valid, chan, raw_count, input ready);
  modport sink   (input valid, chan, raw_count, output ready);
endinterface

>>> rtl/lcc_out_if.sv
interface lcc_out_if;
  logic                              valid;
  logic                              ready;
  logic [lcc_pkg::FREQ_W-1:0]        freq_hz;
  logic signed [lcc_pkg::CAP_W-1:0]  cap_pf_q16;
  logic                              sat_flag;

  modport source (output valid, freq_hz, cap_pf_q16, sat_flag, input ready);
  modport sink   (input valid, freq_hz, cap_pf_q16, sat_flag, output ready);
endinterface

>>> rtl/lcc_cfg_if.sv
interface lcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lcc_pkg::CFG_IDX_W-1:0]  index;
  logic [lcc_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/lcc_div_pipe.sv
module lcc_div_pipe #(
  parameter int DW = 60
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  lcc_pkg::lcc_ctl_t          ctl_in,
  input  logic [DW-1:0]              c_rem_in,
  input  logic [lcc_pkg::QB-1:0]     c_num_in,
  input  logic [DW-1:0]              c_d_in,
  input  logic [lcc_pkg::QB-1:0]     f_num_in,
  input  logic [lcc_pkg::DIV_W-1:0]  f_d_in,
  output lcc_pkg::lcc_ctl_t          ctl_out,
  output logic [lcc_pkg::QB-1:0]     c_q_out,
  output logic [lcc_pkg::QB-1:0]     f_q_out
);
  import lcc_pkg::*;

  // Two restoring dividers in lockstep, one quotient bit per stage.
  lcc_ctl_t         ctl   [0:QB];
  logic [DW-1:0]    c_rem [0:QB];
  logic [QB-1:0]    c_num [0:QB];
  logic [DW-1:0]    c_d   [0:QB];
  logic [QB-1:0]    c_q   [0:QB];
  logic [DIV_W-1:0] f_rem [0:QB];
  logic [QB-1:0]    f_num [0:QB];
  logic [DIV_W-1:0] f_d   [0:QB];
  logic [QB-1:0]    f_q   [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= ctl_in;
    end
    if (en) begin
      c_rem[0] <= c_rem_in;
      c_num[0] <= c_num_in;
      c_d[0]   <= c_d_in;
      c_q[0]   <= '0;
      f_rem[0] <= '0;
      f_num[0] <= f_num_in;
      f_d[0]   <= f_d_in;
      f_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0]    c_t;
    logic           c_ge;
    logic [DIV_W:0] f_t;
    logic           f_ge;

    always_comb begin
      c_t  = {c_rem[k], c_num[k][QB-1]};
      c_ge = c_t >= {1'b0, c_d[k]};
      f_t  = {f_rem[k], f_num[k][QB-1]};
      f_ge = f_t >= {1'b0, f_d[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else if (en) begin
        ctl[k+1] <= ctl[k];
      end
      if (en) begin
        c_rem[k+1] <= c_ge ? DW'(c_t - {1'b0, c_d[k]}) : DW'(c_t);
        c_num[k+1] <= c_num[k] << 1;
        c_d[k+1]   <= c_d[k];
        c_q[k+1]   <= {c_q[k][QB-2:0], c_ge};
        f_rem[k+1] <= f_ge ? DIV_W'(f_t - {1'b0, f_d[k]}) : DIV_W'(f_t);
        f_num[k+1] <= f_num[k] << 1;
        f_d[k+1]   <= f_d[k];
        f_q[k+1]   <= {f_q[k][QB-2:0], f_ge};
      end
    end
  end

  assign ctl_out = ctl[QB];
  assign c_q_out = c_q[QB];
  assign f_q_out = f_q[QB];

endmodule

>>> rtl/lc_sensor_capacitance_convert.sv
// Inputs pass four arithmetic stages, a 33-stage restoring divider behind
// its input register, and an output register. Throughput: one item per
// cycle while the output is not stalled; the divider yields one quotient
// bit per stage for both results. A stalled output freezes the whole
// pipeline, so nothing is lost or repeated. Reset clears all valid bits
// and loads fin_sel = 2 and ref_div = 1 for all four channels.
module lc_sensor_capacitance_convert #(
  parameter int unsigned REF_CLOCK_HZ = lcc_pkg::REF_CLOCK_HZ_DEF,
  parameter int unsigned COUNT_BITS   = lcc_pkg::COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  lcc_in_if.sink    in_ch,
  lcc_out_if.source out_ch,
  lcc_cfg_if.sink   cfg
);
  import lcc_pkg::*;

  localparam int SH   = 2 * int'(COUNT_BITS) - 32;
  localparam int SPOS = (SH > 0) ? SH : 0;
  localparam int SNEG = (SH < 0) ? -SH : 0;
  localparam int CB   = int'(COUNT_BITS);
  localparam int DW   = 2 * CB + 4 + SNEG;
  localparam int PW   = KQ_LW + DIV2_W;
  localparam int MW0  = KQ_W + DIV2_W;
  localparam int MW   = MW0 + SPOS;
  localparam int RW   = MW - QB;

  localparam logic [127:0] KQ_FULL =
    ({64'd0, CAP_K0} << 48) / (128'(REF_CLOCK_HZ) * 128'(REF_CLOCK_HZ));
  localparam logic [KQ_W-1:0]        KQ    = KQ_FULL[KQ_W-1:0];
  localparam logic [KQ_LW-1:0]       KQ_LO = KQ[KQ_LW-1:0];
  localparam logic [KQ_W-KQ_LW-1:0]  KQ_HI = KQ[KQ_W-1:KQ_LW];
  localparam logic [FR_W-1:0]        REF_C = FR_W'(REF_CLOCK_HZ);

  logic [FIN_W-1:0] fin_sel [NUM_CH];
  logic [DIV_W-1:0] ref_div [NUM_CH];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        fin_sel[i] <= FIN_SEL_RESET;
        ref_div[i] <= REF_DIV_RESET;
      end
    end else if (cfg.valid) begin
      if (cfg.index < REG_REF_DIV_CH0) begin
        fin_sel[cfg.index[1:0]] <= cfg.data[FIN_W-1:0];
      end else if (cfg.index < REG_END) begin
        ref_div[cfg.index[1:0]] <= cfg.data;
      end
    end
  end

  logic en;
  logic out_valid;
  lcc_ctl_t div_ctl;
  logic [QB-1:0] c_q, f_q;

  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: register lookup.
  logic             v1, z1;
  logic [FIN_W-1:0] fin1;
  logic [DIV_W-1:0] div1;
  logic [CB-1:0]    cnt1;

  // Stage 2: squares and frequency numerator.
  logic               v2, z2;
  logic [2*CB-1:0]    cnt2;
  logic [3:0]         fin2;
  logic [DIV2_W-1:0]  div2;
  logic [DIV_W-1:0]   dv2;
  logic [FR_W+CB-1:0] fn2;

  // Stage 3: denominator and partial products of the numerator.
  logic             v3, z3;
  logic [DW-1:0]    den3;
  logic [PW-1:0]    pl3, ph3;
  logic [FR_W-1:0]  fn3;
  logic [DIV_W-1:0] dv3;

  // Stage 4: full numerator.
  logic             v4, z4;
  logic [MW-1:0]    m4;
  logic [DW-1:0]    den4;
  logic [FR_W-1:0]  fn4;
  logic [DIV_W-1:0] dv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      fin1 <= fin_sel[in_ch.chan];
      div1 <= (ref_div[in_ch.chan] == '0) ? DIV_W'(1) : ref_div[in_ch.chan];
      cnt1 <= in_ch.raw_count[CB-1:0];
      z1   <= (fin_sel[in_ch.chan] == '0) || (in_ch.raw_count[CB-1:0] == '0);

      z2   <= z1;
      cnt2 <= (2*CB)'(cnt1) * (2*CB)'(cnt1);
      fin2 <= 4'(fin1) * 4'(fin1);
      div2 <= DIV2_W'(div1) * DIV2_W'(div1);
      dv2  <= div1;
      fn2  <= (FR_W+CB)'(REF_C * FR_W'(fin1)) * (FR_W+CB)'(cnt1);

      z3   <= z2;
      den3 <= DW'(DW'(fin2) * DW'(cnt2)) << SNEG;
      pl3  <= PW'(KQ_LO) * PW'(div2);
      ph3  <= PW'(KQ_HI) * PW'(div2);
      fn3  <= fn2[FR_W+CB-1:CB];
      dv3  <= dv2;

      z4   <= z3;
      m4   <= MW'(MW0'(pl3) + (MW0'(ph3) << KQ_LW)) << SPOS;
      den4 <= den3;
      fn4  <= fn3;
      dv4  <= dv3;
    end
  end

  // A quotient of 2^QB or more can only saturate, so it is caught up front.
  logic [RW-1:0] rem0;
  logic          ovf4;
  lcc_ctl_t      ctl4;

  always_comb begin
    rem0       = m4[MW-1:QB];
    ovf4       = rem0 >= {{(RW-DW){1'b0}}, den4};
    ctl4.valid = v4;
    ctl4.zero  = z4;
    ctl4.ovf   = ovf4;
  end

  lcc_div_pipe #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl4),
    .c_rem_in (rem0[DW-1:0]),
    .c_num_in (m4[QB-1:0]),
    .c_d_in   (den4),
    .f_num_in (QB'(fn4)),
    .f_d_in   (dv4),
    .ctl_out  (div_ctl),
    .c_q_out  (c_q),
    .f_q_out  (f_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_ctl.valid;
    end
    if (en) begin
      out_ch.freq_hz <= (f_q > FREQ_MAX) ? FREQ_MAX[FREQ_W-1:0] : f_q[FREQ_W-1:0];
      if (div_ctl.zero || div_ctl.ovf || (c_q > CAP_LIM)) begin
        out_ch.cap_pf_q16 <= CAP_MAX[CAP_W-1:0];
        out_ch.sat_flag   <= 1'b1;
      end else begin
        out_ch.cap_pf_q16 <= CAP_W'(c_q - CAP_OFFSET);
        out_ch.sat_flag   <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid;

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcc_pkg::*;

  localparam logic [127:0] TANK_K0 = 128'd1407238661699000;
  localparam logic [127:0] REF_HZ = 128'd40000000;
  localparam logic [127:0] OFFSET_Q16 = 128'd37 << 16;
  localparam logic [127:0] CAP_TOP = 128'h7FFF_FFFF;
  localparam int SETTLE = 45;
  localparam int WATCHDOG = 4000;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic [CHAN_W-1:0]    chan;
    logic [RAW_W-1:0]     cnt;
  } job_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [CAP_W-1:0]  cap;
    logic              sat;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lcc_in_if  in_bus();
  lcc_out_if out_bus();
  lcc_cfg_if cfg_bus();

  lc_sensor_capacitance_convert uut (
    .clk(clk), .rst(rst), .in_ch(in_bus), .out_ch(out_bus), .cfg(cfg_bus)
  );

  always #5 clk = ~clk;

  job_t     jobs[$];
  reading_t readings_due[$];
  logic [FIN_W-1:0] fin_sel[NUM_CH];
  logic [DIV_W-1:0] ref_div[NUM_CH];
  logic in_acc, cfg_acc;
  int quiet, stalled, mismatches;
  int in_gap, out_gap;
  bit burst;

  function automatic reading_t convert(input logic [CHAN_W-1:0] ch, input logic [RAW_W-1:0] cnt);
    logic [127:0] fin, dv, kq, t;
    reading_t r;
    fin = 128'(fin_sel[ch]);
    dv = (ref_div[ch] == '0) ? 128'd1 : 128'(ref_div[ch]);
    t = (fin * REF_HZ * 128'(cnt)) / (dv << 28);
    r.freq = (t > 128'((1 << FREQ_W) - 1)) ? '1 : t[FREQ_W-1:0];
    if (fin == 0 || cnt == 0) begin
      r.cap = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else begin
      kq = (TANK_K0 << 48) / (REF_HZ * REF_HZ);
      t = ((kq * dv * dv) << 24) / (fin * fin * 128'(cnt) * 128'(cnt));
      if (t > CAP_TOP + OFFSET_Q16) begin
        r.cap = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        t = t - OFFSET_Q16;
        r.cap = t[31:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic add_cfg(input int idx, input int data);
    job_t j;
    j = '{1'b1, CFG_IDX_W'(idx), CFG_DAT_W'(data), '0, '0};
    jobs.push_back(j);
  endtask

  task automatic add_item(input int ch, input logic [RAW_W-1:0] cnt);
    job_t j;
    j = '{1'b0, '0, '0, CHAN_W'(ch), cnt};
    jobs.push_back(j);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Handshake bookkeeping, prediction and checking.
  always @(posedge clk) begin
    reading_t got, want;
    if (rst) begin
      in_acc <= 1'b0;
      cfg_acc <= 1'b0;
      quiet <= 0;
      stalled <= 0;
      for (int i = 0; i < NUM_CH; i++) begin
        fin_sel[i] = FIN_SEL_RESET;
        ref_div[i] = REF_DIV_RESET;
      end
    end else begin
      in_acc <= in_bus.valid && in_bus.ready;
      cfg_acc <= cfg_bus.valid && cfg_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index < REG_REF_DIV_CH0)
          fin_sel[cfg_bus.index[1:0]] = cfg_bus.data[FIN_W-1:0];
        else if (cfg_bus.index < REG_END)
          ref_div[cfg_bus.index[1:0]] = cfg_bus.data;
      end
      if (in_bus.valid && in_bus.ready)
        readings_due.push_back(convert(in_bus.chan, in_bus.raw_count));
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.freq_hz, out_bus.cap_pf_q16, out_bus.sat_flag};
        if (readings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = readings_due.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready)) begin
        quiet <= 0;
        stalled <= 0;
      end else begin
        quiet <= quiet + 1;
        stalled <= stalled + 1;
        if (stalled >= WATCHDOG) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Source side: one pending job at a time; register writes wait for an idle block.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_bus.valid && !in_acc) begin
      end else if (cfg_bus.valid && !cfg_acc) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
        cfg_bus.valid <= 1'b0;
      end else if (jobs.size() != 0 && jobs[0].is_cfg) begin
        in_bus.valid <= 1'b0;
        if (readings_due.size() == 0 && quiet >= SETTLE && !cfg_bus.valid) begin
          cfg_bus.valid <= 1'b1;
          cfg_bus.index <= jobs[0].idx;
          cfg_bus.data <= jobs[0].data;
          void'(jobs.pop_front());
        end else begin
          cfg_bus.valid <= 1'b0;
        end
      end else if (jobs.size() != 0) begin
        cfg_bus.valid <= 1'b0;
        in_bus.valid <= 1'b1;
        in_bus.chan <= jobs[0].chan;
        in_bus.raw_count <= jobs[0].cnt;
        void'(jobs.pop_front());
        in_gap = pick_gap();
      end else begin
        in_bus.valid <= 1'b0;
        cfg_bus.valid <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  initial begin
    logic [RAW_W-1:0] cnt;
    int r;
    in_bus.valid = 1'b0;
    in_bus.chan = '0;
    in_bus.raw_count = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    in_gap = 0;
    out_gap = 0;
    mismatches = 0;
    burst = 0;

    // Reset settings: zero count, full count and one count on every channel.
    for (int ch = 0; ch < NUM_CH; ch++) begin
      add_item(ch, '0);
      add_item(ch, '1);
      add_item(ch, 28'd1);
    end
    // Largest multiplier and divider, then a zero multiplier and a zero divider.
    for (int ch = 0; ch < NUM_CH; ch++) begin
      add_cfg(REG_FIN_SEL_CH0 + ch, 10'h3FF);
      add_cfg(REG_REF_DIV_CH0 + ch, 1023);
    end
    add_cfg(REG_FIN_SEL_CH0 + 1, 0);
    add_cfg(REG_REF_DIV_CH0 + 2, 0);
    add_cfg(REG_END, 10'h155);
    add_cfg(15, 10'h2AA);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      add_item(ch, '1);
      add_item(ch, 28'd1);
      add_item(ch, 28'h5555555);
    end

    for (int ph = 0; ph < 10; ph++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        add_cfg(REG_FIN_SEL_CH0 + ch, ($urandom_range(0, 255) << 2) | $urandom_range(0, 3));
        r = $urandom_range(0, 3);
        add_cfg(REG_REF_DIV_CH0 + ch, r == 0 ? 1 : r == 1 ? 1023 : r == 2 ? 0
                                      : $urandom_range(0, 1023));
      end
      if ($urandom_range(0, 1)) add_cfg($urandom_range(8, 15), $urandom_range(0, 1023));
      for (int n = 0; n < 103; n++) begin
        cnt = RAW_W'($urandom);
        r = $urandom_range(0, 9);
        if (r < 4) cnt = cnt & RAW_W'((64'd1 << $urandom_range(1, 28)) - 1);
        else if (r == 4) cnt = RAW_W'($urandom_range(0, 3));
        add_item($urandom_range(0, 3), cnt);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    r = 0;
    while (jobs.size() != 0 || in_bus.valid || cfg_bus.valid || readings_due.size() != 0) begin
      @(posedge clk);
      r++;
      if (r % 100 == 0) burst = ($urandom_range(0, 3) == 0);
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
